// ===== src/ntske_pkg.sv =====
package ntske_pkg;

   localparam int COOKIE_SLOT_COUNT_DEF = 8;
   localparam int MAX_COOKIE_BYTES_DEF  = 256;
   localparam int MAX_BODY_BYTES_DEF    = 256;

   // Item kinds on the request channel.
   localparam logic [1:0] FUNC_HEADER = 2'd0;
   localparam logic [1:0] FUNC_BODY   = 2'd1;
   localparam logic [1:0] FUNC_END    = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_VALID   = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_READ    = 2'd2;

   // NTS-KE record types.
   localparam logic [14:0] TYPE_NEXT_PROTO = 15'd1;
   localparam logic [14:0] TYPE_ERROR      = 15'd2;
   localparam logic [14:0] TYPE_WARNING    = 15'd3;
   localparam logic [14:0] TYPE_AEAD       = 15'd4;
   localparam logic [14:0] TYPE_COOKIE     = 15'd5;
   localparam logic [14:0] TYPE_SERVER     = 15'd6;
   localparam logic [14:0] TYPE_PORT       = 15'd7;

   localparam logic [15:0] AEAD_CMAC = 16'd15;
   localparam logic [15:0] AEAD_GCM  = 16'd30;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CMAC_EN = 2'd0;
   localparam logic [1:0] CSR_GCM_EN  = 2'd1;

   localparam logic [7:0]  PRINT_LOW       = 8'h21;
   localparam logic [7:0]  PRINT_HIGH      = 8'h7E;
   localparam logic [15:0] FIXED_FIELD_LEN = 16'd2;

   // Everything a result needs that is known when its item is accepted.
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] aead;
      logic [3:0]  count;
      logic [15:0] port;
      logic [8:0]  name_len;
      logic        hit;
      logic [7:0]  offset;
   } rsp_info_type;

endpackage

// ===== src/nts_ke_response_record_checker.sv =====
// A verdict or read reply passes from the read stage, which waits for the cookie memory
// read, to the output register.
// Throughput: one item per cycle unless stalled; header and body items give no result.
// The request side stalls only when the read stage and the output both hold a result.
// Reset is synchronous: it clears the message state and sets both AEAD enables.
// The cookie memories are not cleared; stale entries from earlier messages are never reported.
module nts_ke_response_record_checker #(
   parameter int COOKIE_SLOT_COUNT = ntske_pkg::COOKIE_SLOT_COUNT_DEF,
   parameter int MAX_COOKIE_BYTES  = ntske_pkg::MAX_COOKIE_BYTES_DEF,
   parameter int MAX_BODY_BYTES    = ntske_pkg::MAX_BODY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic        req_critical_bit,
   input  logic [14:0] req_record_type,
   input  logic [15:0] req_body_length,
   input  logic [7:0]  req_body_byte,
   input  logic [2:0]  req_cookie_index,
   input  logic [7:0]  req_byte_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_aead_code,
   output logic [3:0]  rsp_cookie_count,
   output logic [15:0] rsp_ntp_port,
   output logic [8:0]  rsp_server_name_length,
   output logic [7:0]  rsp_read_byte,
   output logic [8:0]  rsp_read_length,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic        csr_wdata
);
   import ntske_pkg::*;

   localparam int DEPTH = COOKIE_SLOT_COUNT * MAX_COOKIE_BYTES;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = (COOKIE_SLOT_COUNT > 1) ? $clog2(COOKIE_SLOT_COUNT) : 1;
   localparam int CLW   = $clog2(MAX_COOKIE_BYTES + 1);

   logic           accept, push, push_ready;
   rsp_info_type   info;
   logic           byte_we, byte_re, len_we, len_re;
   logic [AW-1:0]  byte_waddr, byte_raddr;
   logic [7:0]     byte_wdata, byte_rdata;
   logic [IW-1:0]  len_waddr, len_raddr;
   logic [CLW-1:0] len_wdata, len_rdata;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign push      = accept && ((req_func == FUNC_END) || (req_func == FUNC_READ));

   ntske_parser #(
      .COOKIE_SLOT_COUNT (COOKIE_SLOT_COUNT),
      .MAX_COOKIE_BYTES  (MAX_COOKIE_BYTES),
      .MAX_BODY_BYTES    (MAX_BODY_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (req_func),
      .critical_bit (req_critical_bit),
      .record_type  (req_record_type),
      .body_length  (req_body_length),
      .body_byte    (req_body_byte),
      .cookie_index (req_cookie_index),
      .byte_offset  (req_byte_offset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .info         (info),
      .byte_we      (byte_we),
      .byte_waddr   (byte_waddr),
      .byte_wdata   (byte_wdata),
      .byte_re      (byte_re),
      .byte_raddr   (byte_raddr),
      .len_we       (len_we),
      .len_waddr    (len_waddr),
      .len_wdata    (len_wdata),
      .len_re       (len_re),
      .len_raddr    (len_raddr)
   );

   ntske_cookie_mem #(
      .COOKIE_SLOT_COUNT (COOKIE_SLOT_COUNT),
      .MAX_COOKIE_BYTES  (MAX_COOKIE_BYTES)
   ) u_cookie_mem (
      .clock      (clock),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_re    (byte_re),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .len_we     (len_we),
      .len_waddr  (len_waddr),
      .len_wdata  (len_wdata),
      .len_re     (len_re),
      .len_raddr  (len_raddr),
      .len_rdata  (len_rdata)
   );

   ntske_rsp_pipe #(
      .MAX_COOKIE_BYTES (MAX_COOKIE_BYTES)
   ) u_rsp_pipe (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .info                   (info),
      .push_ready             (push_ready),
      .byte_rdata             (byte_rdata),
      .len_rdata              (len_rdata),
      .rsp_ready              (rsp_ready),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_aead_code          (rsp_aead_code),
      .rsp_cookie_count       (rsp_cookie_count),
      .rsp_ntp_port           (rsp_ntp_port),
      .rsp_server_name_length (rsp_server_name_length),
      .rsp_read_byte          (rsp_read_byte),
      .rsp_read_length        (rsp_read_length)
   );

endmodule

// ===== src/ntske_cookie_mem.sv =====
module ntske_cookie_mem #(
   parameter int COOKIE_SLOT_COUNT = ntske_pkg::COOKIE_SLOT_COUNT_DEF,
   parameter int MAX_COOKIE_BYTES  = ntske_pkg::MAX_COOKIE_BYTES_DEF,
   localparam int DEPTH = COOKIE_SLOT_COUNT * MAX_COOKIE_BYTES,
   localparam int AW    = $clog2(DEPTH),
   localparam int IW    = (COOKIE_SLOT_COUNT > 1) ? $clog2(COOKIE_SLOT_COUNT) : 1,
   localparam int CLW   = $clog2(MAX_COOKIE_BYTES + 1)
) (
   input  logic           clock,
   input  logic           byte_we,
   input  logic [AW-1:0]  byte_waddr,
   input  logic [7:0]     byte_wdata,
   input  logic           byte_re,
   input  logic [AW-1:0]  byte_raddr,
   output logic [7:0]     byte_rdata,
   input  logic           len_we,
   input  logic [IW-1:0]  len_waddr,
   input  logic [CLW-1:0] len_wdata,
   input  logic           len_re,
   input  logic [IW-1:0]  len_raddr,
   output logic [CLW-1:0] len_rdata
);
   logic [7:0]     byte_mem_ff [DEPTH];
   logic [CLW-1:0] len_mem_ff [COOKIE_SLOT_COUNT];
   logic [7:0]     byte_rdata_ff;
   logic [CLW-1:0] len_rdata_ff;

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem_ff[byte_waddr] <= byte_wdata;
      end
      if (byte_re) begin
         byte_rdata_ff <= byte_mem_ff[byte_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem_ff[len_waddr] <= len_wdata;
      end
      if (len_re) begin
         len_rdata_ff <= len_mem_ff[len_raddr];
      end
   end

   assign byte_rdata = byte_rdata_ff;
   assign len_rdata  = len_rdata_ff;

endmodule

// ===== src/ntske_parser.sv =====
module ntske_parser #(
   parameter int COOKIE_SLOT_COUNT = ntske_pkg::COOKIE_SLOT_COUNT_DEF,
   parameter int MAX_COOKIE_BYTES  = ntske_pkg::MAX_COOKIE_BYTES_DEF,
   parameter int MAX_BODY_BYTES    = ntske_pkg::MAX_BODY_BYTES_DEF,
   localparam int DEPTH = COOKIE_SLOT_COUNT * MAX_COOKIE_BYTES,
   localparam int AW    = $clog2(DEPTH),
   localparam int IW    = (COOKIE_SLOT_COUNT > 1) ? $clog2(COOKIE_SLOT_COUNT) : 1,
   localparam int CLW   = $clog2(MAX_COOKIE_BYTES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               func,
   input  logic                     critical_bit,
   input  logic [14:0]              record_type,
   input  logic [15:0]              body_length,
   input  logic [7:0]               body_byte,
   input  logic [2:0]               cookie_index,
   input  logic [7:0]               byte_offset,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic                     csr_wdata,
   output ntske_pkg::rsp_info_type  info,
   output logic                     byte_we,
   output logic [AW-1:0]            byte_waddr,
   output logic [7:0]               byte_wdata,
   output logic                     byte_re,
   output logic [AW-1:0]            byte_raddr,
   output logic                     len_we,
   output logic [IW-1:0]            len_waddr,
   output logic [CLW-1:0]           len_wdata,
   output logic                     len_re,
   output logic [IW-1:0]            len_raddr
);
   import ntske_pkg::*;

   localparam int HW  = $clog2(COOKIE_SLOT_COUNT + 1);
   localparam int NLW = $clog2(MAX_BODY_BYTES + 1);
   localparam logic [HW-1:0] COOKIE_SLOTS = HW'(COOKIE_SLOT_COUNT);
   localparam logic [16:0]   COOKIE_MAX   = 17'(MAX_COOKIE_BYTES);
   localparam logic [16:0]   BODY_MAX     = 17'(MAX_BODY_BYTES);

   logic           cmac_en_ff, cmac_en_in;
   logic           gcm_en_ff, gcm_en_in;
   logic           open_ff, open_in;
   logic           error_ff, error_in;
   logic           proto_ff, proto_in;
   logic [15:0]    aead_val_ff, aead_val_in;
   logic           aead_seen_ff, aead_seen_in;
   logic [15:0]    port_ff, port_in;
   logic [NLW-1:0] name_len_ff, name_len_in;
   logic [HW-1:0]  held_ff, held_in;
   logic           crit_ff, crit_in;
   logic [14:0]    type_ff, type_in;
   logic [15:0]    len_ff, len_in;
   logic [15:0]    seen_ff, seen_in;
   logic [15:0]    fw_ff, fw_in;
   logic           print_ff, print_in;

   // State as seen once a message is open: a closed message reads as reset.
   logic           eff_error, eff_proto, eff_aead_seen;
   logic [15:0]    eff_aead_val, eff_port;
   logic [NLW-1:0] eff_name_len;
   logic [HW-1:0]  eff_held;

   logic           fin_en, fin_crit, fin_print, fin_take;
   logic [14:0]    fin_type;
   logic [15:0]    fin_len, fin_fw;
   logic           msg_ok, read_hit;

   function automatic logic cookie_ok(logic [14:0] rtype, logic [15:0] rlen,
                                      logic [HW-1:0] held);
      cookie_ok = (rtype == TYPE_COOKIE) && (rlen != 16'd0) &&
                  ({1'b0, rlen} <= COOKIE_MAX) && (rlen[1:0] == 2'b00) &&
                  (held < COOKIE_SLOTS);
   endfunction

   always_comb begin
      eff_error     = open_ff & error_ff;
      eff_proto     = open_ff & proto_ff;
      eff_aead_seen = open_ff & aead_seen_ff;
      eff_aead_val  = open_ff ? aead_val_ff : 16'd0;
      eff_port      = open_ff ? port_ff : 16'd0;
      eff_name_len  = open_ff ? name_len_ff : '0;
      eff_held      = open_ff ? held_ff : '0;
   end

   always_comb begin
      cmac_en_in   = cmac_en_ff;
      gcm_en_in    = gcm_en_ff;
      open_in      = open_ff;
      error_in     = error_ff;
      proto_in     = proto_ff;
      aead_val_in  = aead_val_ff;
      aead_seen_in = aead_seen_ff;
      port_in      = port_ff;
      name_len_in  = name_len_ff;
      held_in      = held_ff;
      crit_in      = crit_ff;
      type_in      = type_ff;
      len_in       = len_ff;
      seen_in      = seen_ff;
      fw_in        = fw_ff;
      print_in     = print_ff;

      fin_en    = 1'b0;
      fin_crit  = crit_ff;
      fin_type  = type_ff;
      fin_len   = len_ff;
      fin_fw    = fw_ff;
      fin_print = print_ff;

      byte_we    = 1'b0;
      byte_waddr = AW'(32'(held_ff) * MAX_COOKIE_BYTES + 32'(seen_ff));
      byte_wdata = body_byte;

      if (csr_write_en) begin
         case (csr_index)
            CSR_CMAC_EN: cmac_en_in = csr_wdata;
            CSR_GCM_EN:  gcm_en_in  = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         case (func)
            FUNC_HEADER: begin
               open_in      = 1'b1;
               error_in     = eff_error;
               proto_in     = eff_proto;
               aead_val_in  = eff_aead_val;
               aead_seen_in = eff_aead_seen;
               port_in      = eff_port;
               name_len_in  = eff_name_len;
               held_in      = eff_held;
               if (!open_ff) begin
                  crit_in  = 1'b0;
                  type_in  = '0;
                  len_in   = '0;
                  seen_in  = '0;
                  fw_in    = '0;
                  print_in = 1'b1;
               end
               if (!eff_error) begin
                  crit_in  = critical_bit;
                  type_in  = record_type;
                  len_in   = body_length;
                  seen_in  = '0;
                  fw_in    = '0;
                  print_in = 1'b1;
                  if ({1'b0, body_length} > BODY_MAX) begin
                     if (critical_bit) begin
                        error_in = 1'b1;
                     end
                  end else if (body_length == 16'd0) begin
                     // An empty record is judged right at its header.
                     fin_en    = 1'b1;
                     fin_crit  = critical_bit;
                     fin_type  = record_type;
                     fin_len   = body_length;
                     fin_fw    = '0;
                     fin_print = 1'b1;
                  end
               end
            end
            FUNC_BODY: begin
               if (open_ff && !error_ff && (seen_ff < len_ff)) begin
                  seen_in = seen_ff + 16'd1;
                  if ({1'b0, len_ff} <= BODY_MAX) begin
                     if (seen_ff == 16'd0) begin
                        fw_in = {body_byte, 8'h00};
                     end else if (seen_ff == 16'd1) begin
                        fw_in = fw_ff | {8'h00, body_byte};
                     end
                     if ((body_byte < PRINT_LOW) || (body_byte > PRINT_HIGH)) begin
                        print_in = 1'b0;
                     end
                     byte_we = cookie_ok(type_ff, len_ff, held_ff);
                     if (seen_in == len_ff) begin
                        fin_en    = 1'b1;
                        fin_fw    = fw_in;
                        fin_print = print_in;
                     end
                  end
               end
            end
            FUNC_END: begin
               open_in      = 1'b0;
               error_in     = eff_error;
               proto_in     = eff_proto;
               aead_val_in  = eff_aead_val;
               aead_seen_in = eff_aead_seen;
               port_in      = eff_port;
               name_len_in  = eff_name_len;
               held_in      = eff_held;
               crit_in      = 1'b0;
               type_in      = '0;
               len_in       = '0;
               seen_in      = '0;
               if (!open_ff) begin
                  fw_in    = '0;
                  print_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      fin_take  = cookie_ok(fin_type, fin_len, held_in);
      len_we    = 1'b0;
      len_waddr = IW'(held_in);
      len_wdata = CLW'(fin_len);

      if (fin_en) begin
         case (fin_type)
            TYPE_NEXT_PROTO: begin
               if (!fin_crit || (fin_len != FIXED_FIELD_LEN) || (fin_fw != 16'd0)) begin
                  error_in = 1'b1;
               end else begin
                  proto_in = 1'b1;
               end
            end
            TYPE_AEAD: begin
               if ((fin_len == FIXED_FIELD_LEN) &&
                   (((fin_fw == AEAD_CMAC) && cmac_en_ff) ||
                    ((fin_fw == AEAD_GCM) && gcm_en_ff))) begin
                  aead_val_in  = fin_fw;
                  aead_seen_in = 1'b1;
               end else begin
                  error_in = 1'b1;
               end
            end
            TYPE_ERROR, TYPE_WARNING: error_in = 1'b1;
            TYPE_COOKIE: begin
               if (fin_take) begin
                  len_we  = 1'b1;
                  held_in = held_in + HW'(1);
               end
            end
            TYPE_SERVER: begin
               if ((fin_len == 16'd0) || !fin_print) begin
                  error_in = 1'b1;
               end else begin
                  name_len_in = NLW'(fin_len);
               end
            end
            TYPE_PORT: begin
               if (fin_len != FIXED_FIELD_LEN) begin
                  error_in = 1'b1;
               end else begin
                  port_in = fin_fw;
               end
            end
            default: begin
               if (fin_crit) begin
                  error_in = 1'b1;
               end
            end
         endcase
      end
   end

   // Result fields: a verdict sees the message as opened, a read sees what is held.
   always_comb begin
      msg_ok   = !eff_error && (eff_held != '0) && eff_proto && eff_aead_seen;
      read_hit = (32'(cookie_index) < 32'(held_ff)) &&
                 (32'(cookie_index) < COOKIE_SLOT_COUNT);
      if (func == FUNC_READ) begin
         info.status   = STATUS_READ;
         info.aead     = aead_val_ff;
         info.count    = 4'(held_ff);
         info.port     = port_ff;
         info.name_len = 9'(name_len_ff);
         info.hit      = read_hit;
      end else begin
         info.status   = msg_ok ? STATUS_VALID : STATUS_INVALID;
         info.aead     = eff_aead_val;
         info.count    = 4'(eff_held);
         info.port     = eff_port;
         info.name_len = 9'(eff_name_len);
         info.hit      = 1'b0;
      end
      info.offset = byte_offset;

      len_re     = accept && (func == FUNC_READ) && read_hit;
      len_raddr  = IW'(cookie_index);
      byte_re    = len_re && (32'(byte_offset) < MAX_COOKIE_BYTES);
      byte_raddr = AW'(32'(cookie_index) * MAX_COOKIE_BYTES + 32'(byte_offset));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmac_en_ff   <= 1'b1;
         gcm_en_ff    <= 1'b1;
         open_ff      <= 1'b0;
         error_ff     <= 1'b0;
         proto_ff     <= 1'b0;
         aead_val_ff  <= '0;
         aead_seen_ff <= 1'b0;
         port_ff      <= '0;
         name_len_ff  <= '0;
         held_ff      <= '0;
         crit_ff      <= 1'b0;
         type_ff      <= '0;
         len_ff       <= '0;
         seen_ff      <= '0;
         fw_ff        <= '0;
         print_ff     <= 1'b1;
      end else begin
         cmac_en_ff   <= cmac_en_in;
         gcm_en_ff    <= gcm_en_in;
         open_ff      <= open_in;
         error_ff     <= error_in;
         proto_ff     <= proto_in;
         aead_val_ff  <= aead_val_in;
         aead_seen_ff <= aead_seen_in;
         port_ff      <= port_in;
         name_len_ff  <= name_len_in;
         held_ff      <= held_in;
         crit_ff      <= crit_in;
         type_ff      <= type_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         fw_ff        <= fw_in;
         print_ff     <= print_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) held_ff <= COOKIE_SLOTS)
      else $error("cookie count exceeds the number of slots");

   assert property (@(posedge clock) disable iff (reset)
      byte_we |-> open_ff && !error_ff && (type_ff == TYPE_COOKIE))
      else $error("cookie byte written outside an open cookie record");

   assert property (@(posedge clock) disable iff (reset)
      len_we |=> held_ff == $past(held_ff) + HW'(1))
      else $error("cookie length stored without advancing the cookie count");

endmodule

// ===== src/ntske_rsp_pipe.sv =====
module ntske_rsp_pipe #(
   parameter int MAX_COOKIE_BYTES = ntske_pkg::MAX_COOKIE_BYTES_DEF,
   localparam int CLW = $clog2(MAX_COOKIE_BYTES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ntske_pkg::rsp_info_type info,
   output logic                    push_ready,
   input  logic [7:0]              byte_rdata,
   input  logic [CLW-1:0]          len_rdata,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_aead_code,
   output logic [3:0]              rsp_cookie_count,
   output logic [15:0]             rsp_ntp_port,
   output logic [8:0]              rsp_server_name_length,
   output logic [7:0]              rsp_read_byte,
   output logic [8:0]              rsp_read_length
);
   import ntske_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   rsp_info_type s1_info_ff, s1_info_in;
   logic         out_valid_ff, out_valid_in;
   logic [1:0]   status_ff, status_in;
   logic [15:0]  aead_ff, aead_in;
   logic [3:0]   count_ff, count_in;
   logic [15:0]  port_ff, port_in;
   logic [8:0]   name_len_ff, name_len_in;
   logic [7:0]   rbyte_ff, rbyte_in;
   logic [8:0]   rlen_ff, rlen_in;
   logic         s1_move;

   // Stage one waits for the memory read data; the output register holds
   // a finished item while the consumer stalls.
   always_comb begin
      s1_move    = s1_valid_ff && (!out_valid_ff || rsp_ready);
      push_ready = !s1_valid_ff || s1_move;

      s1_valid_in = push ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_info_in  = push ? info : s1_info_ff;

      out_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      status_in    = status_ff;
      aead_in      = aead_ff;
      count_in     = count_ff;
      port_in      = port_ff;
      name_len_in  = name_len_ff;
      rbyte_in     = rbyte_ff;
      rlen_in      = rlen_ff;
      if (s1_move) begin
         status_in   = s1_info_ff.status;
         aead_in     = s1_info_ff.aead;
         count_in    = s1_info_ff.count;
         port_in     = s1_info_ff.port;
         name_len_in = s1_info_ff.name_len;
         rlen_in     = s1_info_ff.hit ? 9'(len_rdata) : 9'd0;
         rbyte_in    = (s1_info_ff.hit && (32'(s1_info_ff.offset) < 32'(len_rdata))) ?
                       byte_rdata : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff  <= s1_info_in;
      status_ff   <= status_in;
      aead_ff     <= aead_in;
      count_ff    <= count_in;
      port_ff     <= port_in;
      name_len_ff <= name_len_in;
      rbyte_ff    <= rbyte_in;
      rlen_ff     <= rlen_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_aead_code          = aead_ff;
   assign rsp_cookie_count       = count_ff;
   assign rsp_ntp_port           = port_ff;
   assign rsp_server_name_length = name_len_ff;
   assign rsp_read_byte          = rbyte_ff;
   assign rsp_read_length        = rlen_ff;

   assert property (@(posedge clock) disable iff (reset) push |-> push_ready)
      else $error("item pushed while the read stage is blocked");

   assert property (@(posedge clock) disable iff (reset) s1_move |=> out_valid_ff)
      else $error("item left the read stage but did not reach the output");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (status_ff != STATUS_READ) |-> (rbyte_ff == 8'd0) && (rlen_ff == 9'd0))
      else $error("verdict carries cookie read data");

endmodule
